// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker of this project.
// Depends on nothing; every macro expects a clock named clock, and ASSERT_CLK and ASSERT_NEVER a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Property that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/core/agf_pkg.sv =====
// Package of the axial gravity force core: payload types, register codes,
// pipeline depths and the step functions of the square root and divider pipes.
package agf_pkg;

   // Pipeline depths.
   localparam int PRE_STAGES   = 11;
   localparam int SQRT_STEPS   = 31;
   localparam int SQRT_STAGES  = (SQRT_STEPS + 1) / 2;
   localparam int DIV_STEPS    = 17;
   localparam int DIV_STAGES   = (DIV_STEPS + 1) / 2;
   localparam int TOTAL_STAGES = PRE_STAGES + SQRT_STAGES + DIV_STAGES + 1;
   localparam int TAIL_STAGES  = SQRT_STAGES + DIV_STAGES;

   // Block-scaling targets: bit position of the leading one.
   localparam logic [5:0] VEC_TOP = 6'd19;
   localparam logic [5:0] W_TOP   = 6'd29;

   typedef enum logic [2:0] {
      CSR_AXIS_PX = 3'd0,
      CSR_AXIS_PY = 3'd1,
      CSR_AXIS_PZ = 3'd2,
      CSR_AXIS_DX = 3'd3,
      CSR_AXIS_DY = 3'd4,
      CSR_AXIS_DZ = 3'd5,
      CSR_PULL    = 3'd6,
      CSR_GROUP   = 3'd7
   } csr_idx_type;

   localparam logic signed [31:0] DIR_Z_RESET = 32'sd65536;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        body_mass;
      logic [15:0]        group_bits;
      logic               is_clump;
   } agf_req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic               applied;
   } agf_rsp_type;

   // Per-item control that rides along the datapath.
   typedef struct packed {
      logic        skip;
      logic        aneg;
      logic [47:0] fq;
   } side_type;

   typedef struct packed {
      logic        skip;
      logic        aneg;
      logic [2:0]  wneg;
      logic [47:0] fq;
   } tail_type;

   typedef struct packed {
      logic [61:0] rem;
      logic [30:0] root;
   } sq_state_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [16:0] q;
      logic        lsb;
   } dv_state_type;

   typedef dv_state_type [2:0] dv_lanes_type;

   // Position of the leading one; zero for a zero word.
   function automatic logic [5:0] lead_pos(logic [63:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) p = 6'(i);
      end
      return p;
   endfunction

   // Shift a magnitude so that its leading one moves from p to top.
   // Right shifts truncate.
   function automatic logic [63:0] scale_mag(logic [63:0] m, logic [5:0] p,
                                             logic [5:0] top);
      logic [63:0] r;
      if (p > top) begin
         r = m >> (p - top);
      end else begin
         r = m << (top - p);
      end
      return r;
   endfunction

   // One digit of the integer square root; k is the result bit decided.
   function automatic sq_state_type sqrt_step(sq_state_type s, int k);
      logic [63:0]  t;
      sq_state_type o;
      t = ({33'd0, s.root} << (k + 1)) + (64'd1 << (2 * k));
      o = s;
      if ({2'b00, s.rem} >= t) begin
         o.rem  = 62'({2'b00, s.rem} - t);
         o.root = s.root | (31'd1 << k);
      end
      return o;
   endfunction

   // One quotient bit of restoring division; j counts steps from the top.
   function automatic dv_state_type div_step(dv_state_type s, logic [30:0] len, int j);
      logic [31:0]  r2;
      dv_state_type o;
      o  = s;
      r2 = {s.rem, (j == 0) ? s.lsb : 1'b0};
      if (r2 >= {1'b0, len}) begin
         r2 = r2 - {1'b0, len};
         o.q[DIV_STEPS - 1 - j] = 1'b1;
      end
      o.rem = r2[30:0];
      return o;
   endfunction

endpackage

// ===== rtl/core/agf_sqrt_pipe.sv =====
// Pipelined integer square root, two result bits per stage, one in the last stage.
// Depends on agf_pkg for the stage count and the step function.
module agf_sqrt_pipe
   import agf_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [61:0] sum_i,
   output logic [30:0] root_o
);

   sq_state_type st_ff  [SQRT_STAGES];
   sq_state_type src    [SQRT_STAGES];
   sq_state_type st_in  [SQRT_STAGES];

   // Stage zero takes the radicand with an empty root.
   assign src[0] = '{rem: sum_i, root: '0};

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      localparam int K1 = SQRT_STEPS - 1 - 2 * s;
      localparam int K2 = K1 - 1;

      if (s > 0) begin : g_link
         assign src[s] = st_ff[s-1];
      end

      // Decide two root bits, or one in the last stage.
      always_comb begin
         st_in[s] = sqrt_step(src[s], K1);
         if (K2 >= 0) begin
            st_in[s] = sqrt_step(st_in[s], K2);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign root_o = st_ff[SQRT_STAGES-1].root;

endmodule

// ===== rtl/core/agf_div_pipe.sv =====
// Pipelined restoring divider for three lanes sharing one divisor,
// two quotient bits per stage, one in the last stage. Depends on agf_pkg.
module agf_div_pipe
   import agf_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [2:0][29:0] wm_i,
   input  logic [30:0]      len_i,
   output logic [2:0][16:0] quo_o
);

   dv_lanes_type st_ff  [DIV_STAGES];
   dv_lanes_type src    [DIV_STAGES];
   dv_lanes_type st_in  [DIV_STAGES];
   logic [30:0]  len_ff [DIV_STAGES];
   logic [30:0]  len_src[DIV_STAGES];

   // The dividend is the magnitude times 2^16; its upper bits start the remainder.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         src[0][l].rem = {2'b00, wm_i[l][29:1]};
         src[0][l].q   = '0;
         src[0][l].lsb = wm_i[l][0];
      end
   end
   assign len_src[0] = len_i;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int J1 = 2 * s;
      localparam int J2 = J1 + 1;

      if (s > 0) begin : g_link
         assign src[s]     = st_ff[s-1];
         assign len_src[s] = len_ff[s-1];
      end

      // Two quotient bits per lane, one in the last stage.
      always_comb begin
         st_in[s] = src[s];
         for (int l = 0; l < 3; l++) begin
            st_in[s][l] = div_step(st_in[s][l], len_src[s], J1);
            if (J2 < DIV_STEPS) begin
               st_in[s][l] = div_step(st_in[s][l], len_src[s], J2);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s]  <= st_in[s];
            len_ff[s] <= len_src[s];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         quo_o[l] = st_ff[DIV_STAGES-1][l].q;
      end
   end

endmodule

// ===== rtl/core/axial_gravity_force_core.sv =====
// Axial gravity force core: force on a body toward a configured axis line.
// Throughput: one body per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: axis point at the origin, direction +z, zero pull, no group filter.
module axial_gravity_force_core
   import agf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  agf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output agf_rsp_type rsp_data,
   input  logic        csr_we,
   input  csr_idx_type csr_addr,
   input  logic [31:0] csr_wdata
);

   // Configuration registers.
   logic signed [31:0] ap_ff [3];
   logic signed [31:0] dir_ff[3];
   logic signed [31:0] acc_ff;
   logic [15:0]        gf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ap_ff[0]  <= '0;
         ap_ff[1]  <= '0;
         ap_ff[2]  <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RESET;
         acc_ff    <= '0;
         gf_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_AXIS_PX: ap_ff[0]  <= csr_wdata;
            CSR_AXIS_PY: ap_ff[1]  <= csr_wdata;
            CSR_AXIS_PZ: ap_ff[2]  <= csr_wdata;
            CSR_AXIS_DX: dir_ff[0] <= csr_wdata;
            CSR_AXIS_DY: dir_ff[1] <= csr_wdata;
            CSR_AXIS_DZ: dir_ff[2] <= csr_wdata;
            CSR_PULL:    acc_ff    <= csr_wdata;
            CSR_GROUP:   gf_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves unless a finished result is held.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // Valid bits that travel with the data.
   logic [TOTAL_STAGES-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[TOTAL_STAGES-2:0], req_valid};
         rsp_valid_ff <= vld_ff[TOTAL_STAGES-1];
      end
   end

   // Stage 1: offset from the axis point, mass times pull, filters.
   logic signed [32:0] s1_v_in[3], s1_v_ff[3];
   side_type           s1_side_in, s1_side_ff;
   logic signed [31:0] pos[3];
   logic [31:0]        acc_mag;
   logic [63:0]        fprod;

   always_comb begin
      pos[0] = req_data.pos_x;
      pos[1] = req_data.pos_y;
      pos[2] = req_data.pos_z;
      for (int i = 0; i < 3; i++) begin
         s1_v_in[i] = 33'(pos[i]) - 33'(ap_ff[i]);
      end
      acc_mag = acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff);
      fprod   = 64'(acc_mag) * 64'(req_data.body_mass);
      s1_side_in.fq   = fprod[63:16];
      s1_side_in.aneg = acc_ff[31];
      s1_side_in.skip = req_data.is_clump ||
                        ((gf_ff != '0) && ((req_data.group_bits & gf_ff) == '0));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_v_ff    <= s1_v_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // Stage 2: magnitudes, signs and leading-one positions of V and D.
   logic [32:0] s2_vm_in[3], s2_vm_ff[3];
   logic [31:0] s2_dm_in[3], s2_dm_ff[3];
   logic [2:0]  s2_vn_in, s2_vn_ff, s2_dn_in, s2_dn_ff;
   logic [5:0]  s2_vp_in, s2_vp_ff, s2_dp_in, s2_dp_ff;
   side_type    s2_side_in, s2_side_ff;
   logic [32:0] vor;
   logic [31:0] dor;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_vn_in[i] = s1_v_ff[i][32];
         s2_vm_in[i] = s1_v_ff[i][32] ? 33'(-s1_v_ff[i]) : 33'(s1_v_ff[i]);
         s2_dn_in[i] = dir_ff[i][31];
         s2_dm_in[i] = dir_ff[i][31] ? 32'(-dir_ff[i]) : 32'(dir_ff[i]);
      end
      vor = s2_vm_in[0] | s2_vm_in[1] | s2_vm_in[2];
      dor = s2_dm_in[0] | s2_dm_in[1] | s2_dm_in[2];
      s2_vp_in = lead_pos(64'(vor));
      s2_dp_in = lead_pos(64'(dor));
      s2_side_in = s1_side_ff;
      s2_side_in.skip = s1_side_ff.skip || (vor == '0) || (dor == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_vm_ff   <= s2_vm_in;
         s2_dm_ff   <= s2_dm_in;
         s2_vn_ff   <= s2_vn_in;
         s2_dn_ff   <= s2_dn_in;
         s2_vp_ff   <= s2_vp_in;
         s2_dp_ff   <= s2_dp_in;
         s2_side_ff <= s2_side_in;
      end
   end

   // Stage 3: block-scale V and D to a 20-bit leading magnitude.
   logic signed [20:0] s3_vs_in[3], s3_vs_ff[3], s3_ds_in[3], s3_ds_ff[3];
   side_type           s3_side_ff;
   logic [20:0]        vsc, dsc;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsc = 21'(scale_mag(64'(s2_vm_ff[i]), s2_vp_ff, VEC_TOP));
         dsc = 21'(scale_mag(64'(s2_dm_ff[i]), s2_dp_ff, VEC_TOP));
         s3_vs_in[i] = s2_vn_ff[i] ? -$signed(vsc) : $signed(vsc);
         s3_ds_in[i] = s2_dn_ff[i] ? -$signed(dsc) : $signed(dsc);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_vs_ff   <= s3_vs_in;
         s3_ds_ff   <= s3_ds_in;
         s3_side_ff <= s2_side_ff;
      end
   end

   // Stage 4: component products for V.D and D.D.
   logic signed [41:0] s4_pvd_in[3], s4_pvd_ff[3], s4_pdd_in[3], s4_pdd_ff[3];
   logic signed [20:0] s4_vs_ff[3], s4_ds_ff[3];
   side_type           s4_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_pvd_in[i] = 42'(s3_vs_ff[i]) * 42'(s3_ds_ff[i]);
         s4_pdd_in[i] = 42'(s3_ds_ff[i]) * 42'(s3_ds_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_pvd_ff  <= s4_pvd_in;
         s4_pdd_ff  <= s4_pdd_in;
         s4_vs_ff   <= s3_vs_ff;
         s4_ds_ff   <= s3_ds_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // Stage 5: dot products.
   logic signed [43:0] s5_vd_in, s5_vd_ff, s5_dd_in, s5_dd_ff;
   logic signed [20:0] s5_vs_ff[3], s5_ds_ff[3];
   side_type           s5_side_ff;

   always_comb begin
      s5_vd_in = 44'(s4_pvd_ff[0]) + 44'(s4_pvd_ff[1]) + 44'(s4_pvd_ff[2]);
      s5_dd_in = 44'(s4_pdd_ff[0]) + 44'(s4_pdd_ff[1]) + 44'(s4_pdd_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_vd_ff   <= s5_vd_in;
         s5_dd_ff   <= s5_dd_in;
         s5_vs_ff   <= s4_vs_ff;
         s5_ds_ff   <= s4_ds_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   // Stage 6: (V.D)*D and (D.D)*V.
   logic signed [63:0] s6_a_in[3], s6_a_ff[3], s6_b_in[3], s6_b_ff[3];
   side_type           s6_side_ff;
   logic signed [64:0] pa, pb;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa = 65'(s5_vd_ff) * 65'(s5_ds_ff[i]);
         pb = 65'(s5_dd_ff) * 65'(s5_vs_ff[i]);
         s6_a_in[i] = 64'(pa);
         s6_b_in[i] = 64'(pb);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_a_ff    <= s6_a_in;
         s6_b_ff    <= s6_b_in;
         s6_side_ff <= s5_side_ff;
      end
   end

   // Stage 7: W and its magnitudes and signs.
   logic [62:0]        s7_wm_in[3], s7_wm_ff[3];
   logic [2:0]         s7_wn_in, s7_wn_ff;
   side_type           s7_side_ff;
   logic signed [63:0] wv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wv = s6_a_ff[i] - s6_b_ff[i];
         s7_wn_in[i] = wv[63];
         s7_wm_in[i] = wv[63] ? 63'(-wv) : 63'(wv);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_wm_ff   <= s7_wm_in;
         s7_wn_ff   <= s7_wn_in;
         s7_side_ff <= s6_side_ff;
      end
   end

   // Stage 8: leading-one position of W; a zero W skips the body.
   logic [62:0] s8_wm_ff[3];
   logic [2:0]  s8_wn_ff;
   logic [5:0]  s8_wp_in, s8_wp_ff;
   side_type    s8_side_in, s8_side_ff;
   logic [62:0] w_or;

   always_comb begin
      w_or       = s7_wm_ff[0] | s7_wm_ff[1] | s7_wm_ff[2];
      s8_wp_in   = lead_pos({1'b0, w_or});
      s8_side_in = s7_side_ff;
      s8_side_in.skip = s7_side_ff.skip || (w_or == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_wm_ff   <= s7_wm_ff;
         s8_wn_ff   <= s7_wn_ff;
         s8_wp_ff   <= s8_wp_in;
         s8_side_ff <= s8_side_in;
      end
   end

   // Stage 9: block-scale W to a 30-bit leading magnitude.
   logic [2:0][29:0] s9_w_in, s9_w_ff;
   logic [2:0]       s9_wn_ff;
   side_type         s9_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s9_w_in[i] = 30'(scale_mag({1'b0, s8_wm_ff[i]}, s8_wp_ff, W_TOP));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_w_ff    <= s9_w_in;
         s9_wn_ff   <= s8_wn_ff;
         s9_side_ff <= s8_side_ff;
      end
   end

   // Stage 10: squares of the scaled components.
   logic [59:0]      s10_sq_in[3], s10_sq_ff[3];
   logic [2:0][29:0] s10_w_ff;
   logic [2:0]       s10_wn_ff;
   side_type         s10_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s10_sq_in[i] = 60'(s9_w_ff[i]) * 60'(s9_w_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_sq_ff   <= s10_sq_in;
         s10_w_ff    <= s9_w_ff;
         s10_wn_ff   <= s9_wn_ff;
         s10_side_ff <= s9_side_ff;
      end
   end

   // Stage 11: squared length.
   logic [61:0]      s11_sum_in, s11_sum_ff;
   logic [2:0][29:0] s11_w_ff;
   tail_type         s11_tail_in, s11_tail_ff;

   always_comb begin
      s11_sum_in = 62'(s10_sq_ff[0]) + 62'(s10_sq_ff[1]) + 62'(s10_sq_ff[2]);
      s11_tail_in.skip = s10_side_ff.skip;
      s11_tail_in.aneg = s10_side_ff.aneg;
      s11_tail_in.wneg = s10_wn_ff;
      s11_tail_in.fq   = s10_side_ff.fq;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_sum_ff  <= s11_sum_in;
         s11_w_ff    <= s10_w_ff;
         s11_tail_ff <= s11_tail_in;
      end
   end

   // Length of W.
   logic [30:0] root;

   agf_sqrt_pipe u_sqrt (
      .clock  (clock),
      .adv    (adv),
      .sum_i  (s11_sum_ff),
      .root_o (root)
   );

   // Components and control delayed to meet the root and the quotients.
   logic [2:0][29:0] wdly_ff [SQRT_STAGES];
   tail_type         tdly_ff [TAIL_STAGES];

   always_ff @(posedge clock) begin
      if (adv) begin
         wdly_ff[0] <= s11_w_ff;
         tdly_ff[0] <= s11_tail_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            wdly_ff[i] <= wdly_ff[i-1];
         end
         for (int i = 1; i < TAIL_STAGES; i++) begin
            tdly_ff[i] <= tdly_ff[i-1];
         end
      end
   end

   // Unit vector components, Q1.16 magnitudes.
   logic [2:0][16:0] quo;

   agf_div_pipe u_div (
      .clock (clock),
      .adv   (adv),
      .wm_i  (wdly_ff[SQRT_STAGES-1]),
      .len_i (root),
      .quo_o (quo)
   );

   // Final multiply: force magnitude per axis.
   logic [48:0] sm_fm_in[3], sm_fm_ff[3];
   tail_type    sm_tail_ff;
   logic [64:0] fmp;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fmp = 65'(tdly_ff[TAIL_STAGES-1].fq) * 65'(quo[i]);
         sm_fm_in[i] = fmp[64:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_fm_ff   <= sm_fm_in;
         sm_tail_ff <= tdly_ff[TAIL_STAGES-1];
      end
   end

   // Sign and saturation into the output register.
   agf_rsp_type        rsp_in, rsp_ff;
   logic signed [31:0] fr[3];
   logic [48:0]        fmc;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fmc = '0;
         if (sm_tail_ff.skip || (sm_fm_ff[i] == '0)) begin
            fr[i] = '0;
         end else if (sm_tail_ff.aneg != sm_tail_ff.wneg[i]) begin
            fmc   = (sm_fm_ff[i] > 49'h0_8000_0000) ? 49'h0_8000_0000 : sm_fm_ff[i];
            fr[i] = 32'(-fmc);
         end else begin
            fmc   = (sm_fm_ff[i] > 49'h0_7FFF_FFFF) ? 49'h0_7FFF_FFFF : sm_fm_ff[i];
            fr[i] = 32'(fmc);
         end
      end
      rsp_in.force_x = fr[0];
      rsp_in.force_y = fr[1];
      rsp_in.force_z = fr[2];
      rsp_in.applied = !sm_tail_ff.skip;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/agf_checker.sv =====
// Port-level checker for the axial gravity force core, bound to the top level.
// Depends on agf_pkg and on assert_macros.svh.
`include "assert_macros.svh"

module agf_checker
   import agf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input agf_rsp_type rsp_data
);

   // The pipeline comes out of reset empty.
   `ASSERT_CLK(a_empty_after_reset, $fell(reset) |-> !rsp_valid, "result valid after reset")

   // A held result keeps its payload until the transfer.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // A skipped body carries no force.
   `ASSERT_NEVER(a_skip_zero, rsp_valid && !rsp_data.applied && (rsp_data.force_x != '0 || rsp_data.force_y != '0 || rsp_data.force_z != '0), "skipped body with force")

   // When the output drains, the input side is ready too.
   `ASSERT_CLK(a_ready_when_drain, rsp_valid && rsp_ready |-> req_ready, "input blocked while output drains")

endmodule

bind axial_gravity_force_core agf_checker u_agf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/agf_force_checker.sv =====
// Checker for the axial gravity force core: mirrors the registers, predicts each force.
// Compares each result with the oldest prediction. Depends on agf_pkg.
`timescale 1ns / 100ps

module agf_force_checker
   import agf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  agf_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  agf_rsp_type rsp_data,
   input  logic        csr_we,
   input  csr_idx_type csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          forces_pending,
   output int          forces_seen,
   output int          forces_applied
);

   // Register mirror: axis point, axis direction, pull and group filter.
   logic signed [31:0] axis_pt [3];
   logic signed [31:0] axis_dir [3];
   logic signed [31:0] pull;
   logic [15:0]        group_mask;

   agf_rsp_type expected_forces [$];

   assign forces_pending = expected_forces.size();

   function automatic logic [63:0] mag(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   // Shift three magnitudes together so the largest lands in [2^(top-1), 2^top).
   function automatic bit fit_scale(inout logic [63:0] m [3], input int top);
      logic [63:0] mx;
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << top)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << (top - 1))) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      return 1'b1;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= res + probe) begin
            n   = n - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Force on one body under the current register settings.
   function automatic agf_rsp_type pull_force(agf_req_type b);
      longint      v [3];
      longint      d [3];
      longint      w [3];
      longint      vd;
      longint      dd;
      logic [63:0] vm [3];
      logic [63:0] dm [3];
      logic [63:0] wm [3];
      logic [63:0] sum, len, accm, fq, u, fm;
      logic [31:0] f [3];
      logic [31:0] pos [3];
      bit          aneg, neg;
      agf_rsp_type r;
      r = '0;
      if (b.is_clump) return r;
      if (group_mask != 0 && (b.group_bits & group_mask) == 0) return r;
      pos[0] = b.pos_x;
      pos[1] = b.pos_y;
      pos[2] = b.pos_z;
      for (int i = 0; i < 3; i++) begin
         v[i]  = longint'($signed(pos[i])) - longint'(axis_pt[i]);
         vm[i] = mag(v[i]);
         dm[i] = mag(longint'(axis_dir[i]));
      end
      if (!fit_scale(dm, 20)) return r;
      if (!fit_scale(vm, 20)) return r;
      for (int i = 0; i < 3; i++) begin
         d[i] = (axis_dir[i] < 0) ? -longint'(dm[i]) : longint'(dm[i]);
         v[i] = (v[i] < 0) ? -longint'(vm[i]) : longint'(vm[i]);
      end
      vd = 0;
      dd = 0;
      for (int i = 0; i < 3; i++) begin
         vd += v[i] * d[i];
         dd += d[i] * d[i];
      end
      for (int i = 0; i < 3; i++) begin
         w[i]  = vd * d[i] - dd * v[i];
         wm[i] = mag(w[i]);
      end
      if (!fit_scale(wm, 30)) return r;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += wm[i] * wm[i];
      len = root_floor(sum);
      if (len == 0) return r;
      aneg = pull < 0;
      accm = mag(longint'(pull));
      fq   = (accm * {32'd0, b.body_mass}) >> 16;
      for (int i = 0; i < 3; i++) begin
         u   = (wm[i] << 16) / len;
         fm  = (fq * u) >> 16;
         neg = aneg != (w[i] < 0);
         if (fm == 0) begin
            f[i] = '0;
         end else if (neg) begin
            if (fm > 64'h8000_0000) fm = 64'h8000_0000;
            f[i] = 32'(64'd0 - fm);
         end else begin
            if (fm > 64'h7FFF_FFFF) fm = 64'h7FFF_FFFF;
            f[i] = fm[31:0];
         end
      end
      r.force_x = f[0];
      r.force_y = f[1];
      r.force_z = f[2];
      r.applied = 1'b1;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: force mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count     = 0;
      forces_seen    = 0;
      forces_applied = 0;
   end

   // Register writes, body transfers and result transfers, all at the rising edge.
   always @(posedge clock) begin
      agf_rsp_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            axis_pt[i]  <= '0;
            axis_dir[i] <= '0;
         end
         axis_dir[2] <= DIR_Z_RESET;
         pull        <= '0;
         group_mask  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_AXIS_PX: axis_pt[0]  <= csr_wdata;
               CSR_AXIS_PY: axis_pt[1]  <= csr_wdata;
               CSR_AXIS_PZ: axis_pt[2]  <= csr_wdata;
               CSR_AXIS_DX: axis_dir[0] <= csr_wdata;
               CSR_AXIS_DY: axis_dir[1] <= csr_wdata;
               CSR_AXIS_DZ: axis_dir[2] <= csr_wdata;
               CSR_PULL:    pull        <= csr_wdata;
               CSR_GROUP:   group_mask  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_forces.push_back(pull_force(req_data));
         if (rsp_valid && rsp_ready) begin
            forces_seen++;
            if (expected_forces.size() == 0) begin
               $display("%0t: result transfer with no body outstanding", $time);
               fail_count++;
            end else begin
               want = expected_forces.pop_front();
               if (want.applied) forces_applied++;
               if (rsp_data.force_x !== want.force_x)
                  report("force_x", rsp_data.force_x, want.force_x);
               if (rsp_data.force_y !== want.force_y)
                  report("force_y", rsp_data.force_y, want.force_y);
               if (rsp_data.force_z !== want.force_z)
                  report("force_z", rsp_data.force_z, want.force_z);
               if (rsp_data.applied !== want.applied)
                  report("applied", 32'(rsp_data.applied), 32'(want.applied));
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the axial gravity force core: clock, reset, bodies and registers.
// Depends on agf_pkg, axial_gravity_force_core and agf_force_checker.
`timescale 1ns / 100ps

module tb;
   import agf_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   agf_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   agf_rsp_type rsp_data;
   logic        csr_we;
   csr_idx_type csr_addr;
   logic [31:0] csr_wdata;

   int fail_count, forces_pending, forces_seen, forces_applied;
   int bodies_sent;
   bit calm;
   int ready_stall;

   axial_gravity_force_core dut (.*);

   agf_force_checker checker_i (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: random stall bursts, none once the run turns calm.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready   <= 1'b1;
         ready_stall <= 0;
      end else if (ready_stall > 0) begin
         rsp_ready   <= 1'b0;
         ready_stall <= ready_stall - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready   <= 1'b0;
         ready_stall <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // One body transfer, after an optional gap; valid stays high between bodies unless a gap is drawn.
   task automatic send_body(agf_req_type b);
      int gap;
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      bodies_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lower valid and let every outstanding force arrive before touching registers.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (forces_pending != 0) @(posedge clock);
      repeat (TOTAL_STAGES + 4) @(posedge clock);
   endtask

   // One register write, with the write port idle again before the task returns.
   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_axis(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [31:0] acc, logic [15:0] grp);
      write_reg(CSR_AXIS_PX, px);
      write_reg(CSR_AXIS_PY, py);
      write_reg(CSR_AXIS_PZ, pz);
      write_reg(CSR_AXIS_DX, dx);
      write_reg(CSR_AXIS_DY, dy);
      write_reg(CSR_AXIS_DZ, dz);
      write_reg(CSR_PULL, acc);
      write_reg(CSR_GROUP, {16'd0, grp});
   endtask

   function automatic agf_req_type make_body(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             logic [31:0] m, logic [15:0] g, logic c);
      agf_req_type b;
      b.pos_x      = x;
      b.pos_y      = y;
      b.pos_z      = z;
      b.body_mass  = m;
      b.group_bits = g;
      b.is_clump   = c;
      return b;
   endfunction

   // Random body: mostly full-range, some near the axis point in x and y, few clumps.
   function automatic agf_req_type random_body(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] az);
      agf_req_type b;
      b = make_body($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         b.pos_x = ax + 32'($signed($urandom_range(0, 64)) - 32);
         b.pos_y = ay + 32'($signed($urandom_range(0, 64)) - 32);
         b.pos_z = az + ($urandom >> $urandom_range(0, 31));
      end
      if ($urandom_range(0, 3) == 0) b.body_mass = $urandom >> $urandom_range(8, 31);
      b.is_clump = ($urandom_range(0, 9) == 0);
      return b;
   endfunction

   initial begin
      logic [31:0] ax, ay, az;
      logic [15:0] grp;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_addr    = CSR_AXIS_PX;
      csr_wdata   = '0;
      calm        = 1'b0;
      bodies_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: axis along z, zero pull: forces are zero; the body on the axis is skipped.
      send_body(make_body(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0));
      send_body(make_body(0, 0, 32'h0005_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
      drain();

      // Directed: unit z axis, strong pull, filter on a middle group.
      load_axis(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0009_CF5C, 16'h00F0);
      send_body(make_body(32'h0003_0000, 32'h0004_0000, 0, 32'h0002_0000, 16'h0010, 1'b0));
      send_body(make_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 16'hFFFF, 1'b0));
      send_body(make_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hFFFF_FFFF, 16'h0080, 1'b0));
      send_body(make_body(32'h0001_0000, 0, 0, 0, 16'h0020, 1'b0));
      send_body(make_body(32'h0001_0000, 0, 0, 32'h0001_0000, 16'h0020, 1'b1));
      send_body(make_body(32'h0001_0000, 0, 0, 32'h0001_0000, 16'h0F0F, 1'b0));
      send_body(make_body(0, 0, 32'h1234_0000, 32'h0001_0000, 16'h0040, 1'b0));
      send_body(make_body(1, 0, 32'h7FFF_0000, 32'h0001_0000, 16'h0040, 1'b0));
      send_body(make_body(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0001_0000, 16'h0040, 1'b0));
      send_body(make_body(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 16'h5555, 1'b0));
      send_body(make_body(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 16'hAAAA, 1'b0));
      drain();

      // Extreme registers: axis point at the corners, skewed direction, most negative pull.
      load_axis(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 16'hFFFF);
      send_body(make_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hFFFF_FFFF, 16'h8000, 1'b0));
      send_body(make_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 16'h0001, 1'b0));
      send_body(make_body(0, 0, 0, 32'hFFFF_FFFF, 16'h0001, 1'b0));
      send_body(make_body(0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 1'b0));
      drain();

      // Zero direction skips every body; pull at its positive extreme.
      load_axis(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 16'h0000);
      send_body(make_body(32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 1'b0));
      send_body(make_body(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0));
      drain();

      // Random phases, each with its own axis and pull; the last one is calm.
      for (int phase = 0; phase < 8; phase++) begin
         ax  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom >> 12;
         ay  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom >> 12;
         az  = $urandom;
         grp = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
         load_axis(ax, ay, az, $urandom >> $urandom_range(0, 24),
                   $urandom >> $urandom_range(0, 24), $urandom,
                   $urandom >> $urandom_range(0, 20), grp);
         if (phase == 7) calm = 1'b1;
         repeat (80) send_body(random_body(ax, ay, az));
         drain();
      end

      req_valid <= 1'b0;
      while (forces_pending != 0) @(posedge clock);
      repeat (TOTAL_STAGES + 10) @(posedge clock);
      $display("Run covered %0d bodies across directed, extreme and random axis settings;",
               bodies_sent);
      $display("%0d forces checked, %0d of them applied.", forces_seen, forces_applied);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
